FILE: rtl/svtd_pkg.sv
// ----------------------------------------------------------------------------
// Sensor value type decoder package
// Shared types, tag constants and helper functions.
// ----------------------------------------------------------------------------
`default_nettype none
package svtd_pkg;

   typedef enum logic [2:0] {
      KIND_NONE     = 3'd0,
      KIND_FLOAT    = 3'd1,
      KIND_UNSIGNED = 3'd2,
      KIND_SIGNED   = 3'd3,
      KIND_FP       = 3'd4,
      KIND_SP       = 3'd5
   } kind_type;

   localparam logic [31:0] TAG_FLT   = 32'h666C_7420;
   localparam logic [15:0] PREFIX_UI = 16'h7569;
   localparam logic [15:0] PREFIX_SI = 16'h7369;
   localparam logic [15:0] PREFIX_FP = 16'h6670;
   localparam logic [15:0] PREFIX_SP = 16'h7370;
   localparam logic [7:0]  EXP_ONES  = 8'hff;

   // Value is sign * mag * 2^-scale, unless special carries finished bits.
   typedef struct packed {
      logic              special;
      logic [63:0]       direct;
      logic              sign;
      logic [63:0]       mag;
      logic signed [8:0] scale;
      kind_type          kind;
   } mid_type;

   function automatic logic [5:0] lead_zeros(input logic [63:0] v);
      logic [5:0] n;
      n = 6'd0;
      for (int i = 0; i < 64; i++) begin
         if (v[i]) begin
            n = 6'(63 - i);
         end
      end
      return n;
   endfunction

   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'h10;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = 5'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = 5'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = 5'(c - 8'h37);
      end
      return r;
   endfunction

endpackage
`default_nettype wire

FILE: rtl/svtd_round.sv
// ----------------------------------------------------------------------------
// Sensor value type decoder rounding stage
// Normalises a magnitude and rounds it to a double, nearest even.
// ----------------------------------------------------------------------------
`default_nettype none
module svtd_round (
   input  wire svtd_pkg::mid_type mid,
   output logic [63:0]            result
);

   logic [5:0]  lz;
   logic [63:0] norm;
   logic [11:0] exp_full;
   logic [62:0] body;
   logic        round_up;

   always_comb begin
      lz       = svtd_pkg::lead_zeros(mid.mag);
      norm     = mid.mag << lz;
      exp_full = 12'd1086 - {6'b0, lz} - {{3{mid.scale[8]}}, mid.scale};
      round_up = norm[10] && ((|norm[9:0]) || norm[11]);
      body     = {exp_full[10:0], norm[62:11]} + {62'b0, round_up};
      if (mid.special) begin
         result = mid.direct;
      end else if (mid.mag == 64'b0) begin
         result = 64'b0;
      end else begin
         result = {mid.sign, body};
      end
   end

endmodule
`default_nettype wire

FILE: rtl/sensor_value_type_decoder.sv
// ----------------------------------------------------------------------------
// Sensor value type decoder
// Turns a tagged sensor value into the bit pattern of an IEEE double.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats on req_* carry the type tag, the declared size and the first
//   eight value bytes. Every input beat gives exactly one result beat on
//   rsp_*, holding the double and the format kind, in order.
//   The path is three register stages: input register, decode register and
//   result register. One beat can be accepted in every cycle while the
//   receiver keeps rsp_ready high.
//   The second stage holds the 64-bit leading-zero count, normalising shift
//   and rounding add, which set the clock period.
//   When the receiver holds rsp_ready low, each stage keeps its beat and
//   req_ready falls once all three stages are full; nothing is dropped.
//   Reset empties all stages; no results are pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none
module sensor_value_type_decoder (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_type_tag,
   input  wire  [5:0]  req_value_size,
   input  wire  [63:0] req_value_bytes,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [63:0] rsp_result_double,
   output logic [2:0]  rsp_format_kind
);

   logic                in_valid_ff;
   logic [31:0]         tag_ff;
   logic [5:0]          size_ff;
   logic [63:0]         bytes_ff;
   logic                mid_valid_ff;
   svtd_pkg::mid_type   mid_ff;
   svtd_pkg::mid_type   mid_in;
   logic                out_valid_ff;
   logic [63:0]         result_ff;
   logic [2:0]          kind_ff;
   logic [63:0]         result_in;
   logic                out_en;
   logic                mid_en;
   logic                in_en;

   assign out_en    = !out_valid_ff || rsp_ready;
   assign mid_en    = !mid_valid_ff || out_en;
   assign in_en     = !in_valid_ff || mid_en;
   assign req_ready = in_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (in_en) begin
            in_valid_ff <= req_valid;
         end
         if (mid_en) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (in_en && req_valid) begin
         tag_ff   <= req_type_tag;
         size_ff  <= req_value_size;
         bytes_ff <= req_value_bytes;
      end
      if (mid_en && in_valid_ff) begin
         mid_ff <= mid_in;
      end
      if (out_en && mid_valid_ff) begin
         result_ff <= result_in;
         kind_ff   <= mid_ff.kind;
      end
   end

   logic [15:0] prefix;
   logic [3:0]  count;
   logic [3:0]  scount;
   logic [31:0] single;
   logic [7:0]  sexp;
   logic [22:0] sman;
   logic [63:0] uval;
   logic [63:0] sval;
   logic [15:0] raw;
   logic [4:0]  digit;

   always_comb begin
      prefix = tag_ff[31:16];
      count  = (size_ff < 6'd8) ? size_ff[3:0] : 4'd8;
      scount = (count == 4'd0) ? 4'd1 : count;
      single = {bytes_ff[39:32], bytes_ff[47:40], bytes_ff[55:48], bytes_ff[63:56]};
      sexp   = single[30:23];
      sman   = single[22:0];
      uval   = bytes_ff >> (7'd64 - {count, 3'b0});
      sval   = 64'($signed(bytes_ff) >>> (7'd64 - {scount, 3'b0}));
      raw    = bytes_ff[63:48];
      digit  = svtd_pkg::hex_digit(tag_ff[7:0]);

      mid_in.special = 1'b0;
      mid_in.direct  = 64'b0;
      mid_in.sign    = 1'b0;
      mid_in.mag     = 64'b0;
      mid_in.scale   = 9'sd0;
      mid_in.kind    = svtd_pkg::KIND_NONE;

      if (tag_ff == svtd_pkg::TAG_FLT && size_ff == 6'd4) begin
         mid_in.kind = svtd_pkg::KIND_FLOAT;
         mid_in.sign = single[31];
         if (sexp == svtd_pkg::EXP_ONES) begin
            mid_in.special = 1'b1;
            mid_in.direct  = {single[31], 11'h7ff, (sman != 23'b0), sman[21:0], 29'b0};
         end else if (sexp == 8'd0) begin
            if (sman == 23'b0) begin
               mid_in.special = 1'b1;
               mid_in.direct  = {single[31], 63'b0};
            end else begin
               mid_in.mag   = {41'b0, sman};
               mid_in.scale = 9'sd149;
            end
         end else begin
            mid_in.mag   = {40'b0, 1'b1, sman};
            mid_in.scale = 9'sd150 - $signed({1'b0, sexp});
         end
      end else if (prefix == svtd_pkg::PREFIX_UI) begin
         mid_in.kind = svtd_pkg::KIND_UNSIGNED;
         mid_in.mag  = uval;
      end else if (prefix == svtd_pkg::PREFIX_SI) begin
         mid_in.kind = svtd_pkg::KIND_SIGNED;
         mid_in.sign = sval[63];
         mid_in.mag  = sval[63] ? (~sval + 64'd1) : sval;
      end else if ((prefix == svtd_pkg::PREFIX_FP || prefix == svtd_pkg::PREFIX_SP)
                   && size_ff == 6'd2 && !digit[4]) begin
         mid_in.kind  = (prefix == svtd_pkg::PREFIX_FP) ? svtd_pkg::KIND_FP
                                                        : svtd_pkg::KIND_SP;
         mid_in.scale = $signed({5'b0, digit[3:0]});
         if (prefix == svtd_pkg::PREFIX_SP && raw[15]) begin
            mid_in.sign = 1'b1;
            mid_in.mag  = {48'b0, 16'(~raw + 16'd1)};
         end else begin
            mid_in.mag = {48'b0, raw};
         end
      end
   end

   svtd_round u_round (
      .mid    (mid_ff),
      .result (result_in)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_result_double = result_ff;
   assign rsp_format_kind   = kind_ff;

endmodule
`default_nettype wire

FILE: bench/sensor_value_type_decoder_tb.sv
// ----------------------------------------------------------------------------
// Sensor value type decoder testbench
// Sends tagged sensor values through the decoder and checks every result
// beat against an in-bench prediction of the decoded double and its format
// kind. Directed cases cover the format boundaries; random traffic follows,
// with idle cycles on both sides and one stretch without any idling.
// ----------------------------------------------------------------------------
`default_nettype none
module sensor_value_type_decoder_tb;

   typedef struct {
      logic [63:0]        dbl;
      svtd_pkg::kind_type kind;
   } decoded_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_type_tag;
   logic [5:0]  req_value_size;
   logic [63:0] req_value_bytes;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [63:0] rsp_result_double;
   logic [2:0]  rsp_format_kind;

   decoded_type decoded_q[$];
   int          mismatches;
   int          cycles;
   int          beats_sent;
   int          beats_checked;
   int          kind_count[6];
   bit          steady;

   localparam int CYCLE_LIMIT = 200000;

   sensor_value_type_decoder dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_type_tag(req_type_tag), .req_value_size(req_value_size),
      .req_value_bytes(req_value_bytes),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_double(rsp_result_double), .rsp_format_kind(rsp_format_kind)
   );

   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   function automatic logic [63:0] widen_float(input logic [31:0] f);
      logic [10:0] de;
      logic [23:0] mm;
      logic [51:0] dm;
      if (f[30:23] == svtd_pkg::EXP_ONES) begin
         dm = {f[22:0], 29'b0};
         if (f[22:0] != 0) begin
            dm[51] = 1'b1;
         end
         return {f[31], 11'h7ff, dm};
      end
      if (f[30:23] == 8'd0) begin
         if (f[22:0] == 0) begin
            return {f[31], 63'b0};
         end
         de = 11'd897;
         mm = {1'b0, f[22:0]};
         while (!mm[23]) begin
            mm = mm << 1;
            de = de - 11'd1;
         end
         return {f[31], de, mm[22:0], 29'b0};
      end
      return {f[31], 11'(f[30:23] + 11'd896), f[22:0], 29'b0};
   endfunction

   // Value is (-1)^neg * mag * 2^-shift, rounded to nearest even.
   function automatic logic [63:0] pack_double(input bit neg, input logic [63:0] mag,
                                               input int shift);
      int          msb;
      int          drop;
      int          expo;
      logic [63:0] keep;
      logic [63:0] rem;
      logic [63:0] half;
      if (mag == 0) begin
         return 64'd0;
      end
      msb = 0;
      for (int i = 0; i < 64; i++) begin
         if (mag[i]) begin
            msb = i;
         end
      end
      expo = msb - shift;
      if (msb <= 52) begin
         keep = mag << (52 - msb);
      end else begin
         drop = msb - 52;
         keep = mag >> drop;
         rem = mag & ((64'd1 << drop) - 64'd1);
         half = 64'd1 << (drop - 1);
         if (rem > half || (rem == half && keep[0])) begin
            keep = keep + 64'd1;
         end
         if (keep[53]) begin
            keep = keep >> 1;
            expo = expo + 1;
         end
      end
      return {neg, 11'(expo + 1023), keep[51:0]};
   endfunction

   function automatic int hex_of(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
   endfunction

   function automatic decoded_type decode_value(input logic [31:0] tag,
                                                input logic [5:0] size,
                                                input logic [63:0] bytes);
      decoded_type r;
      logic [63:0] v;
      logic [15:0] raw;
      bit          neg;
      int          n;
      int          digit;
      r.dbl = 64'd0;
      r.kind = svtd_pkg::KIND_NONE;
      n = size < 8 ? int'(size) : 8;
      if (tag == svtd_pkg::TAG_FLT && size == 6'd4) begin
         r.dbl = widen_float({bytes[39:32], bytes[47:40], bytes[55:48], bytes[63:56]});
         r.kind = svtd_pkg::KIND_FLOAT;
      end else if (tag[31:16] == svtd_pkg::PREFIX_UI) begin
         v = 64'd0;
         for (int i = 0; i < n; i++) begin
            v = (v << 8) | 64'(bytes[63 - 8 * i -: 8]);
         end
         r.dbl = pack_double(1'b0, v, 0);
         r.kind = svtd_pkg::KIND_UNSIGNED;
      end else if (tag[31:16] == svtd_pkg::PREFIX_SI) begin
         v = {{56{bytes[63]}}, bytes[63:56]};
         for (int i = 1; i < n; i++) begin
            v = (v << 8) | 64'(bytes[63 - 8 * i -: 8]);
         end
         r.dbl = pack_double(v[63], v[63] ? -v : v, 0);
         r.kind = svtd_pkg::KIND_SIGNED;
      end else if ((tag[31:16] == svtd_pkg::PREFIX_FP || tag[31:16] == svtd_pkg::PREFIX_SP)
                   && size == 6'd2) begin
         digit = hex_of(tag[7:0]);
         if (digit >= 0) begin
            raw = bytes[63:48];
            if (tag[31:16] == svtd_pkg::PREFIX_SP) begin
               neg = raw[15];
               if (neg) begin
                  raw = ~raw + 16'd1;
               end
               r.dbl = pack_double(neg, 64'(raw), digit);
               r.kind = svtd_pkg::KIND_SP;
            end else begin
               r.dbl = pack_double(1'b0, 64'(raw), digit);
               r.kind = svtd_pkg::KIND_FP;
            end
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("mismatch on %s at result %0d: got %h, expected %h",
               what, beats_checked, got, want);
      mismatches++;
   endtask

   task automatic send_value(input logic [31:0] tag, input logic [5:0] size,
                             input logic [63:0] bytes);
      int gap;
      gap = 0;
      if (!steady && $urandom_range(99) < 31) begin
         gap = 1;
      end
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type_tag <= tag;
      req_value_size <= size;
      req_value_bytes <= bytes;
      do @(posedge clock); while (!req_ready);
      decoded_q.push_back(decode_value(tag, size, bytes));
      beats_sent++;
   endtask

   always @(posedge clock) begin
      rsp_ready <= steady ? 1'b1 : ($urandom_range(99) >= 24);
   end

   always @(posedge clock) begin
      decoded_type want;
      cycles++;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_q.size() == 0) begin
            report_mismatch("unexpected beat", rsp_result_double, 64'd0);
         end else begin
            want = decoded_q.pop_front();
            if (rsp_result_double !== want.dbl) begin
               report_mismatch("result_double", rsp_result_double, want.dbl);
            end
            if (rsp_format_kind !== want.kind) begin
               report_mismatch("format_kind", 64'(rsp_format_kind), 64'(want.kind));
            end
            if (want.kind <= svtd_pkg::KIND_SP) begin
               kind_count[want.kind]++;
            end
         end
         beats_checked++;
      end
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("sensor_value_type_decoder_tb: FAIL");
         $finish;
      end
   end

   task automatic test_float;
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'h0000_803f_0000_0000);
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'h0100_0000_dead_beef);
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'hffff_7f80_0000_0000);
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'h0000_80ff_0000_0000);
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'h0100_c0ff_0000_0000);
      send_value(svtd_pkg::TAG_FLT, 6'd4, 64'h0000_0080_0000_0000);
      send_value(svtd_pkg::TAG_FLT, 6'd3, 64'h0000_803f_0000_0000);
   endtask

   task automatic test_unsigned;
      send_value({svtd_pkg::PREFIX_UI, "8 "}, 6'd0, 64'hffff_ffff_ffff_ffff);
      send_value({svtd_pkg::PREFIX_UI, "64"}, 6'd8, 64'hffff_ffff_ffff_ffff);
      send_value({svtd_pkg::PREFIX_UI, "32"}, 6'd32, 64'h0020_0000_0000_0003);
      send_value({svtd_pkg::PREFIX_UI, "16"}, 6'd2, 64'h1234_5678_0000_0000);
   endtask

   task automatic test_signed;
      send_value({svtd_pkg::PREFIX_SI, "8 "}, 6'd0, 64'h8000_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SI, "8 "}, 6'd1, 64'hff00_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SI, "64"}, 6'd8, 64'h8000_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SI, "64"}, 6'd8, 64'h7fff_ffff_ffff_ffff);
      send_value({svtd_pkg::PREFIX_SI, "16"}, 6'd3, 64'hfe01_8000_0000_0000);
   endtask

   task automatic test_fixed;
      send_value({svtd_pkg::PREFIX_FP, "t0"}, 6'd2, 64'hffff_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_FP, "tf"}, 6'd2, 64'h0001_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SP, "7F"}, 6'd2, 64'h8000_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SP, "7a"}, 6'd2, 64'hfff3_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_FP, "8g"}, 6'd2, 64'h1234_0000_0000_0000);
      send_value({svtd_pkg::PREFIX_SP, "78"}, 6'd3, 64'h1234_0000_0000_0000);
   endtask

   task automatic test_unknown;
      send_value("abcd", 6'd4, 64'h0123_4567_89ab_cdef);
      send_value(32'hffff_ffff, 6'd63, 64'hffff_ffff_ffff_ffff);
   endtask

   task automatic test_random;
      logic [31:0] tag;
      logic [31:0] f;
      logic [63:0] bytes;
      logic [5:0]  size;
      logic [7:0]  digit_chars[22];
      string       digits;
      digits = "0123456789abcdefABCDEF";
      for (int i = 0; i < 22; i++) begin
         digit_chars[i] = digits[i];
      end
      for (int i = 0; i < 650; i++) begin
         steady = (i >= 250 && i < 400);
         bytes = {$urandom, $urandom};
         size = 6'($urandom_range(0, 32));
         case ($urandom_range(0, 9))
            0, 1: begin
               tag = svtd_pkg::TAG_FLT;
               f = $urandom;
               case ($urandom_range(0, 3))
                  0: f[30:23] = 8'd0;
                  1: f[30:23] = svtd_pkg::EXP_ONES;
                  default: ;
               endcase
               if ($urandom_range(0, 3) == 0) f[22:0] = 23'd0;
               bytes[63:32] = {f[7:0], f[15:8], f[23:16], f[31:24]};
               if ($urandom_range(0, 7) != 0) size = 6'd4;
            end
            2, 3: tag = {svtd_pkg::PREFIX_UI, 16'($urandom)};
            4, 5: tag = {svtd_pkg::PREFIX_SI, 16'($urandom)};
            6, 7, 8: begin
               tag = {($urandom_range(0, 1) != 0) ? svtd_pkg::PREFIX_FP : svtd_pkg::PREFIX_SP,
                      16'($urandom)};
               if ($urandom_range(0, 5) != 0) tag[7:0] = digit_chars[$urandom_range(0, 21)];
               if ($urandom_range(0, 7) != 0) size = 6'd2;
            end
            default: tag = $urandom;
         endcase
         send_value(tag, size, bytes);
      end
      steady = 1'b0;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_type_tag = 32'd0;
      req_value_size = 6'd0;
      req_value_bytes = 64'd0;
      rsp_ready = 1'b0;
      steady = 1'b0;
      mismatches = 0;
      cycles = 0;
      beats_sent = 0;
      beats_checked = 0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_float;
      test_unsigned;
      test_signed;
      test_fixed;
      test_unknown;
      test_random;
      req_valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      $display("%0d of %0d values decoded: %0d unknown, %0d float, %0d unsigned,",
               beats_checked, beats_sent, kind_count[0], kind_count[1], kind_count[2]);
      $display("%0d signed, %0d fp and %0d sp; %0d mismatches", kind_count[3],
               kind_count[4], kind_count[5], mismatches);
      if (mismatches == 0) begin
         $display("sensor_value_type_decoder_tb: PASS");
      end else begin
         $display("sensor_value_type_decoder_tb: FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire

FILE: sim.f
rtl/svtd_pkg.sv
rtl/svtd_round.sv
rtl/sensor_value_type_decoder.sv
bench/sensor_value_type_decoder_tb.sv
